>>> rtl/gbf_pkg.sv
// ----------------------------------------------------------------------------
// gbf_pkg
// Shared constants, codes and types of the glyph blitter.
// ----------------------------------------------------------------------------
package gbf_pkg;

   // panel geometry and column-major plane layout
   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 256;
   localparam int COL_STRIDE   = PANEL_HEIGHT / 8 + 1;
   localparam int PLANE_DEPTH  = PANEL_WIDTH * COL_STRIDE;
   localparam int ADDR_W       = $clog2(PLANE_DEPTH);

   // reset contents of the two planes
   localparam logic [7:0] BLACK_RESET = 8'hFF;
   localparam logic [7:0] RED_RESET   = 8'h00;

   // request kinds
   localparam logic REQ_GLYPH = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // plane codes
   localparam logic PLANE_BLACK = 1'b0;
   localparam logic PLANE_RED   = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [2:0] CSR_GLYPH_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_GLYPH_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_PLANE_SELECT = 3'd4;

   typedef struct packed {
      logic [9:0] origin_x;
      logic [9:0] origin_y;
      logic [7:0] glyph_width;
      logic [7:0] glyph_height;
      logic       plane_select;
   } gbf_cfg_type;

   // one memory operation: a pixel read-modify-write or a byte read
   typedef struct packed {
      logic              is_read;
      logic              wr_en;
      logic              plane;
      logic              in_range;
      logic              set_bit;
      logic              last;
      logic              glyph_done;
      logic [3:0]        pixels;
      logic [7:0]        mask;
      logic [ADDR_W-1:0] addr;
   } gbf_op_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] pixels_written;
      logic       glyph_done;
   } gbf_rsp_type;

   // result leaving the write stage
   typedef struct packed {
      logic        valid;
      gbf_rsp_type rsp;
   } gbf_done_type;

endpackage

>>> rtl/gbf_unpack.sv
// ----------------------------------------------------------------------------
// gbf_unpack
// Holds one request, walks a glyph byte one pixel per cycle while advance is high
// through the glyph counters, and issues one plane operation per pixel or per read.
// ----------------------------------------------------------------------------
module gbf_unpack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_type,
   input  logic [7:0]           req_byte,
   input  logic                 req_start,
   input  logic                 req_plane,
   input  logic [12:0]          req_addr,
   input  gbf_pkg::gbf_cfg_type cfg,
   input  logic                 clearing,
   input  logic                 advance,
   output logic                 op_valid,
   output gbf_pkg::gbf_op_type  op
);
   import gbf_pkg::*;

   // held request
   logic        s0_valid_ff, s0_valid_in;
   logic        s0_type_ff;
   logic [7:0]  s0_byte_ff;
   logic        s0_plane_ff;
   logic [12:0] s0_addr_ff;
   logic [2:0]  bit_ff;
   logic [3:0]  cnt_ff;

   // glyph counters
   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] run_ff, run_in;
   logic [7:0] done_ff, done_in;

   logic        accept;
   logic        last_op;
   logic        skip, wrap, row_end, on_panel, drawn, pix_bit;
   logic [7:0]  col_1, row_1, run_1;
   logic [7:0]  col_n, row_n, run_n, done_n;
   logic [10:0] px, py;
   logic [3:0]  pixels;

   // per-pixel counter step
   always_comb begin
      skip    = (done_ff == cfg.glyph_height);
      wrap    = (col_ff == cfg.glyph_width);
      col_1   = wrap ? 8'd0 : col_ff;
      row_1   = wrap ? row_ff + 8'd1 : row_ff;
      run_1   = run_ff + 8'd1;
      row_end = (run_1 == cfg.glyph_width);
      col_n   = skip ? col_ff : col_1 + 8'd1;
      row_n   = skip ? row_ff : row_1;
      run_n   = skip ? run_ff : (row_end ? 8'd0 : run_1);
      done_n  = (skip || !row_end) ? done_ff : done_ff + 8'd1;
   end

   // panel position and plane address of the pixel
   always_comb begin
      px       = {cfg.origin_x[9], cfg.origin_x} + {3'd0, col_1};
      py       = {cfg.origin_y[9], cfg.origin_y} + {3'd0, row_1};
      on_panel = !px[10] && (int'(px) < PANEL_WIDTH) &&
                 !py[10] && (int'(py) < PANEL_HEIGHT);
      drawn    = !skip && on_panel;
      pix_bit  = s0_byte_ff[bit_ff];
      pixels   = cnt_ff + {3'd0, drawn};
   end

   // operation toward the plane memories
   always_comb begin
      op = '0;
      if (s0_type_ff == REQ_READ) begin
         op.is_read    = 1'b1;
         op.plane      = s0_plane_ff;
         op.in_range   = (32'(s0_addr_ff) < PLANE_DEPTH);
         op.addr       = op.in_range ? ADDR_W'(s0_addr_ff) : '0;
         op.last       = 1'b1;
         op.glyph_done = skip;
      end else begin
         op.wr_en      = drawn;
         op.plane      = cfg.plane_select;
         op.set_bit    = (cfg.plane_select == PLANE_RED) ? pix_bit : !pix_bit;
         op.mask       = 8'h80 >> py[2:0];
         op.addr       = ADDR_W'(int'(px[9:0]) * COL_STRIDE + int'(py[9:3]));
         op.last       = (bit_ff == 3'd0);
         op.glyph_done = (done_n == cfg.glyph_height);
         op.pixels     = pixels;
      end
   end

   assign op_valid   = s0_valid_ff;
   assign last_op    = op.last;
   assign req_tready = !clearing && (!s0_valid_ff || (advance && last_op));
   assign accept     = req_tvalid && req_tready;

   // next counter values
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (accept && req_type == REQ_GLYPH && req_start) begin
         col_in  = '0;
         row_in  = '0;
         run_in  = '0;
         done_in = '0;
      end else if (advance && s0_valid_ff && s0_type_ff == REQ_GLYPH) begin
         col_in  = col_n;
         row_in  = row_n;
         run_in  = run_n;
         done_in = done_n;
      end
   end

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (accept)
         s0_valid_in = 1'b1;
      else if (advance && s0_valid_ff && last_op)
         s0_valid_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         run_ff      <= '0;
         done_ff     <= '0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         run_ff      <= run_in;
         done_ff     <= done_in;
      end
   end

   // request hold and bit walk
   always_ff @(posedge clock) begin
      if (accept) begin
         s0_type_ff  <= req_type;
         s0_byte_ff  <= req_byte;
         s0_plane_ff <= req_plane;
         s0_addr_ff  <= req_addr;
         bit_ff      <= 3'd7;
         cnt_ff      <= '0;
      end else if (advance && s0_valid_ff) begin
         bit_ff      <= bit_ff - 3'd1;
         cnt_ff      <= pixels;
      end
   end

   // at most eight pixels per byte
   a_pixels_max: assert property (@(posedge clock) disable iff (reset)
      op_valid |-> (op.pixels <= 4'd8))
      else $error("pixel count above eight");

   // a read leaves the glyph counters alone
   a_read_keeps_counters: assert property (@(posedge clock) disable iff (reset)
      (advance && op_valid && op.is_read && !accept) |=>
         ($stable(done_ff) && $stable(col_ff) && $stable(run_ff)))
      else $error("read request changed glyph counters");

endmodule

>>> rtl/gbf_rmw.sv
// ----------------------------------------------------------------------------
// gbf_rmw
// The two plane memories with their clearing pass after reset, and the
// read-modify-write stage with forwarding of the previous write.
// ----------------------------------------------------------------------------
module gbf_rmw (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 op_valid,
   input  gbf_pkg::gbf_op_type  op,
   output logic                 clearing,
   output gbf_pkg::gbf_done_type done
);
   import gbf_pkg::*;

   logic [7:0] black_mem [PLANE_DEPTH];
   logic [7:0] red_mem   [PLANE_DEPTH];
   logic [7:0] black_rd_ff, red_rd_ff;

   // clearing pass
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   // write stage
   logic        s1_valid_ff;
   gbf_op_type  s1_op_ff;

   // last write, for a read issued in the same cycle
   logic              fwd_valid_ff;
   logic              fwd_plane_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [7:0]        fwd_data_ff;

   logic              fwd_hit, do_write;
   logic [7:0]        base, new_byte;
   logic              black_we, red_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        black_wdata, red_wdata;

   assign clearing = clearing_ff;

   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == ADDR_W'(PLANE_DEPTH - 1))
            clearing_in = 1'b0;
      end
   end

   // modify the byte read from the plane
   always_comb begin
      fwd_hit  = fwd_valid_ff && (fwd_plane_ff == s1_op_ff.plane) &&
                 (fwd_addr_ff == s1_op_ff.addr);
      if (fwd_hit)
         base = fwd_data_ff;
      else
         base = (s1_op_ff.plane == PLANE_RED) ? red_rd_ff : black_rd_ff;
      new_byte = s1_op_ff.set_bit ? (base | s1_op_ff.mask) : (base & ~s1_op_ff.mask);
      do_write = advance && s1_valid_ff && s1_op_ff.wr_en;
   end

   // write port: clearing pass or pixel write
   always_comb begin
      if (clearing_ff) begin
         black_we    = 1'b1;
         red_we      = 1'b1;
         wr_addr     = clear_addr_ff;
         black_wdata = BLACK_RESET;
         red_wdata   = RED_RESET;
      end else begin
         black_we    = do_write && (s1_op_ff.plane == PLANE_BLACK);
         red_we      = do_write && (s1_op_ff.plane == PLANE_RED);
         wr_addr     = s1_op_ff.addr;
         black_wdata = new_byte;
         red_wdata   = new_byte;
      end
   end

   // result of the operation in the write stage
   always_comb begin
      done.valid              = s1_valid_ff && s1_op_ff.last;
      done.rsp.read_data      = (s1_op_ff.is_read && s1_op_ff.in_range) ? base : 8'h00;
      done.rsp.pixels_written = s1_op_ff.pixels;
      done.rsp.glyph_done     = s1_op_ff.glyph_done;
   end

   // plane memories
   always_ff @(posedge clock) begin
      if (black_we)
         black_mem[wr_addr] <= black_wdata;
      if (advance && op_valid)
         black_rd_ff <= black_mem[op.addr];
   end

   always_ff @(posedge clock) begin
      if (red_we)
         red_mem[wr_addr] <= red_wdata;
      if (advance && op_valid)
         red_rd_ff <= red_mem[op.addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         if (advance) begin
            s1_valid_ff  <= op_valid;
            fwd_valid_ff <= do_write;
         end
      end
   end

   // write stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff     <= op;
         fwd_plane_ff <= s1_op_ff.plane;
         fwd_addr_ff  <= s1_op_ff.addr;
         fwd_data_ff  <= new_byte;
      end
   end

   // nothing enters while the planes are being cleared
   a_no_op_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !op_valid)
      else $error("operation issued during clearing pass");

   a_no_write_stage_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff)
      else $error("write stage busy during clearing pass");

endmodule

>>> rtl/glyph_bitmap_to_framebuffer.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_to_framebuffer
// Unpacks 1bpp glyph bytes into a column-major two-plane framebuffer and
// serves byte reads of either plane.
// ----------------------------------------------------------------------------
// path: request register in gbf_unpack, write stage in gbf_rmw, output register
// issue: a glyph byte takes one plane read-modify-write per pixel, a read
//   request a single plane read; the next request is taken as the last
//   operation of the current one issues
// reset: synchronous; afterward both planes are cleared one address per cycle
//   over all PLANE_DEPTH addresses (4224 at 128x256) while req_tready stays low
module glyph_bitmap_to_framebuffer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // glyph_byte[7:0], glyph_start[8],
                                   // read_plane[9], read_address[22:10], zero
   input  logic        req_tuser,  // req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // read_data[7:0], pixels_written[11:8],
                                   // glyph_done[12], zero
   // configuration port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   import gbf_pkg::*;

   gbf_cfg_type  cfg_ff;
   logic         clearing, advance, op_valid;
   gbf_op_type   op;
   gbf_done_type done;

   logic         rsp_valid_ff;
   gbf_rsp_type  rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x     <= '0;
         cfg_ff.origin_y     <= '0;
         cfg_ff.glyph_width  <= 8'd8;
         cfg_ff.glyph_height <= 8'd8;
         cfg_ff.plane_select <= PLANE_BLACK;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:     cfg_ff.origin_x     <= csr_wdata;
            CSR_ORIGIN_Y:     cfg_ff.origin_y     <= csr_wdata;
            CSR_GLYPH_WIDTH:  cfg_ff.glyph_width  <= csr_wdata[7:0];
            CSR_GLYPH_HEIGHT: cfg_ff.glyph_height <= csr_wdata[7:0];
            CSR_PLANE_SELECT: cfg_ff.plane_select <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline moves unless a finished result has nowhere to go
   assign advance = !done.valid || !rsp_valid_ff || rsp_tready;

   gbf_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .req_byte   (req_tdata[7:0]),
      .req_start  (req_tdata[8]),
      .req_plane  (req_tdata[9]),
      .req_addr   (req_tdata[22:10]),
      .cfg        (cfg_ff),
      .clearing   (clearing),
      .advance    (advance),
      .op_valid   (op_valid),
      .op         (op)
   );

   gbf_rmw u_rmw (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .op_valid (op_valid),
      .op       (op),
      .clearing (clearing),
      .done     (done)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (advance && done.valid)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (advance && done.valid)
         rsp_data_ff <= done.rsp;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff.glyph_done, rsp_data_ff.pixels_written,
                        rsp_data_ff.read_data};

endmodule

>>> tb/glyph_bitmap_to_framebuffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_to_framebuffer_tb
// Drives glyph bytes and plane reads into the blitter under random stalls on
// both streams. A scoreboard keeps its own copy of both planes and of the
// glyph counters, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module glyph_bitmap_to_framebuffer_tb;
   import gbf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 12;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int MAX_REPORTS    = 40;

   // mirror of the framebuffer and glyph counters, plus the pending results
   class glyph_blit_scoreboard;
      logic [7:0]        black_mem [PLANE_DEPTH];
      logic [7:0]        red_mem [PLANE_DEPTH];
      logic [7:0]        col_cnt, row_cnt, run_cnt, rows_done;
      logic signed [9:0] origin_x, origin_y;
      logic [7:0]        glyph_width, glyph_height;
      logic              plane_select;
      gbf_rsp_type       queued_results [$];
      int                failures;
      int                reports;

      function new();
         foreach (black_mem[i]) begin
            black_mem[i] = BLACK_RESET;
            red_mem[i]   = RED_RESET;
         end
         col_cnt      = '0;
         row_cnt      = '0;
         run_cnt      = '0;
         rows_done    = '0;
         origin_x     = '0;
         origin_y     = '0;
         glyph_width  = 8'd8;
         glyph_height = 8'd8;
         plane_select = PLANE_BLACK;
         failures     = 0;
         reports      = 0;
      endfunction

      function void set_config(logic [2:0] index, logic [9:0] value);
         case (index)
            CSR_ORIGIN_X:     origin_x = value;
            CSR_ORIGIN_Y:     origin_y = value;
            CSR_GLYPH_WIDTH:  glyph_width = value[7:0];
            CSR_GLYPH_HEIGHT: glyph_height = value[7:0];
            CSR_PLANE_SELECT: plane_select = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return queued_results.size();
      endfunction

      // store one pixel at the current counters; 1 when it lands on the panel
      function bit plot_pixel(logic ink);
         int         px, py, c, r, addr;
         logic [7:0] mask;
         c  = col_cnt;
         r  = row_cnt;
         px = origin_x;
         px = px + c;
         py = origin_y;
         py = py + r;
         if (px < 0 || px >= PANEL_WIDTH || py < 0 || py >= PANEL_HEIGHT)
            return 1'b0;
         addr = px * COL_STRIDE + py / 8;
         if (addr >= PLANE_DEPTH)
            return 1'b0;
         mask = 8'h80 >> py[2:0];
         if (plane_select == PLANE_RED) begin
            if (ink) red_mem[addr] = red_mem[addr] | mask;
            else     red_mem[addr] = red_mem[addr] & ~mask;
         end else begin
            if (ink) black_mem[addr] = black_mem[addr] & ~mask;
            else     black_mem[addr] = black_mem[addr] | mask;
         end
         return 1'b1;
      endfunction

      // predict the result of an accepted request
      function void note_request(logic kind, logic [23:0] data);
         gbf_rsp_type exp_rsp;
         logic [7:0]  gbyte;
         logic        start, plane;
         logic [12:0] addr;
         gbyte   = data[7:0];
         start   = data[8];
         plane   = data[9];
         addr    = data[22:10];
         exp_rsp = '0;
         if (kind == REQ_READ) begin
            if (addr < PLANE_DEPTH)
               exp_rsp.read_data = (plane == PLANE_RED) ? red_mem[addr] : black_mem[addr];
         end else begin
            if (start) begin
               col_cnt   = '0;
               row_cnt   = '0;
               run_cnt   = '0;
               rows_done = '0;
            end
            // msb first; bits past the last row are skipped
            for (int i = 7; i >= 0; i--) begin
               if (rows_done != glyph_height) begin
                  if (col_cnt == glyph_width) begin
                     col_cnt = '0;
                     row_cnt = row_cnt + 8'd1;
                  end
                  exp_rsp.pixels_written = exp_rsp.pixels_written + 4'(plot_pixel(gbyte[i]));
                  col_cnt = col_cnt + 8'd1;
                  run_cnt = run_cnt + 8'd1;
                  if (run_cnt == glyph_width) begin
                     rows_done = rows_done + 8'd1;
                     run_cnt   = '0;
                  end
               end
            end
         end
         exp_rsp.glyph_done = (rows_done == glyph_height);
         queued_results.push_back(exp_rsp);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            failures++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
         end
      endfunction

      // compare an accepted result with the oldest prediction
      function void check_result(logic [15:0] data);
         gbf_rsp_type want;
         if (queued_results.size() == 0) begin
            failures++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t: unexpected result, expected none, actual %h", $time, data);
            end
            return;
         end
         want = queued_results.pop_front();
         compare_field("read_data", want.read_data, data[7:0]);
         compare_field("pixels_written", want.pixels_written, data[11:8]);
         compare_field("glyph_done", want.glyph_done, data[12]);
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // glyph_byte[7:0], glyph_start[8], read_plane[9],
                                  // read_address[22:10], zero
   logic        req_tuser = REQ_GLYPH; // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // read_data[7:0], pixels_written[11:8],
                                  // glyph_done[12], zero
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_ORIGIN_X;
   logic [9:0]  csr_wdata = '0;

   bit          no_idle = 1'b0;
   bit          hold_rsp = 1'b0;
   int          items_sent = 0;

   glyph_blit_scoreboard blit_sb = new();

   glyph_bitmap_to_framebuffer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // offer one request after a random gap and wait for its transfer
   task automatic send_item(logic kind, logic [23:0] data);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      blit_sb.note_request(kind, data);
      items_sent++;
   endtask

   // read fields are don't-care on a glyph byte, so they get random values
   task automatic send_glyph(logic [7:0] gbyte, logic start);
      send_item(REQ_GLYPH, {1'b0, 13'($urandom), 1'($urandom), start, gbyte});
   endtask

   task automatic send_read(logic plane, int addr);
      send_item(REQ_READ, {1'b0, 13'(addr), plane, 1'($urandom), 8'($urandom)});
   endtask

   // read somewhere random, or near the glyph being drawn
   task automatic send_probe(int ox, int oy, int w, int h);
      int col, row;
      if ($urandom_range(0, 2) == 0) begin
         send_read(1'($urandom), $urandom_range(0, 8191));
      end else begin
         col = ox + $urandom_range(0, (w > 0) ? w - 1 : 7);
         row = oy + $urandom_range(0, h);
         if (col < 0) col = 0;
         if (col > PANEL_WIDTH - 1) col = PANEL_WIDTH - 1;
         if (row < 0) row = 0;
         if (row > PANEL_HEIGHT - 1) row = PANEL_HEIGHT - 1;
         send_read(1'($urandom), col * COL_STRIDE + row / 8);
      end
   endtask

   // drop valid and wait until the block has nothing in flight
   task automatic end_phase();
      req_tvalid <= 1'b0;
      while (blit_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // back-to-back writes keep the enable high; the caller lowers it
   task automatic write_reg(logic [2:0] index, logic [9:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      blit_sb.set_config(index, value);
   endtask

   task automatic configure(int ox, int oy, int w, int h, logic plane);
      write_reg(CSR_ORIGIN_X, 10'(ox));
      write_reg(CSR_ORIGIN_Y, 10'(oy));
      write_reg(CSR_GLYPH_WIDTH, 10'(w));
      write_reg(CSR_GLYPH_HEIGHT, 10'(h));
      write_reg(CSR_PLANE_SELECT, 10'(plane));
      csr_we <= 1'b0;
   endtask

   // one setting, then a few glyphs with random content and stray reads
   task automatic random_phase(bit with_hold);
      int   ox, oy, w, h, pick, n_bytes;
      logic plane;
      pick  = $urandom_range(0, 9);
      plane = 1'($urandom);
      if (with_hold) begin
         ox = 10;
         oy = 20;
         w  = 16;
         h  = 16;
      end else if (pick == 0) begin
         // widest glyphs, zero width and tallest heights
         ox = int'($urandom_range(0, 147)) - 20;
         oy = int'($urandom_range(0, 275)) - 20;
         w  = $urandom_range(0, 1) ? 0 : 255;
         h  = $urandom_range(0, 1) ? 255 : $urandom_range(0, 255);
      end else if (pick <= 2) begin
         // origins from -256 to 511 of the signed register range
         case ($urandom_range(0, 2))
            0:       ox = -256;
            1:       ox = 511;
            default: ox = int'($urandom_range(0, 767)) - 256;
         endcase
         case ($urandom_range(0, 2))
            0:       oy = -256;
            1:       oy = 511;
            default: oy = int'($urandom_range(0, 767)) - 256;
         endcase
         w = $urandom_range(1, 16);
         h = $urandom_range(0, 16);
      end else begin
         ox = int'($urandom_range(0, 147)) - 20;
         oy = int'($urandom_range(0, 275)) - 20;
         w  = $urandom_range(1, 16);
         h  = $urandom_range(1, 16);
      end
      configure(ox, oy, w, h, plane);
      no_idle = with_hold || ($urandom_range(0, 3) == 0);
      if (with_hold)
         hold_rsp = 1'b1;
      repeat ($urandom_range(1, 3)) begin
         n_bytes = (w == 0) ? 40 : (w * h + 7) / 8 + $urandom_range(0, 2);
         if (n_bytes > 48) n_bytes = 48;
         if (n_bytes < 1) n_bytes = 1;
         for (int b = 0; b < n_bytes; b++) begin
            if ($urandom_range(0, 3) == 0)
               send_probe(ox, oy, w, h);
            // an occasional restart in mid glyph
            send_glyph(8'($urandom), (b == 0) || ($urandom_range(0, 31) == 0));
         end
      end
      end_phase();
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : result_sink
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         blit_sb.check_result(rsp_tdata);
      end
   end

   // ends the run when no transfer happens for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : main_sequence
      int random_start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset contents, plane depth edges and out-of-range reads
      send_read(PLANE_BLACK, 0);
      send_read(PLANE_RED, 0);
      send_read(PLANE_BLACK, PLANE_DEPTH - 1);
      send_read(PLANE_RED, PLANE_DEPTH);
      send_read(PLANE_BLACK, 8191);
      // one full 8x8 glyph at the reset setting, then a skipped byte
      send_glyph(8'hFF, 1'b1);
      send_glyph(8'h00, 1'b0);
      send_glyph(8'hA5, 1'b0);
      send_glyph(8'h5A, 1'b0);
      send_glyph(8'h81, 1'b0);
      send_glyph(8'h7E, 1'b0);
      send_glyph(8'hC3, 1'b0);
      send_glyph(8'h3C, 1'b0);
      send_glyph(8'hFF, 1'b0);
      send_read(PLANE_BLACK, 0);
      send_read(PLANE_BLACK, COL_STRIDE);
      end_phase();

      // whole glyph off the panel, zero width
      configure(511, -256, 0, 255, PLANE_RED);
      send_glyph(8'hFF, 1'b1);
      end_phase();

      // zero height skips every bit
      configure(120, 250, 16, 0, PLANE_RED);
      send_glyph(8'h00, 1'b1);
      end_phase();

      // glyph just left of the panel, next to the top left corner
      configure(-3, -3, 3, 4, PLANE_RED);
      send_glyph(8'hFF, 1'b1);
      send_glyph(8'h96, 1'b0);
      send_read(PLANE_RED, 0);
      end_phase();

      // zero width: the first bit wraps to the next row, later bits run on along it
      configure(0, 0, 0, 2, PLANE_BLACK);
      send_glyph(8'hF0, 1'b1);
      send_glyph(8'h0F, 1'b0);
      send_read(PLANE_BLACK, 0);
      end_phase();

      // random phases, the first one with a long result hold-off
      random_start = items_sent;
      random_phase(1'b1);
      while (items_sent - random_start < RANDOM_ITEMS)
         random_phase(1'b0);

      end_phase();
      if (blit_sb.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
